// ===== rtl/core/iost_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered set table package
// Shared constants, request codes and the finish record passed from the
// controller to the result stage.
// ----------------------------------------------------------------------------
package iost_pkg;

    // Default number of entries the set can hold.
    localparam int CAPACITY_DEFAULT = 16;

    // Fixed field widths of the request and result items.
    localparam int REQ_W       = 2;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD      = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_CONTAINS = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_type_t;

    // Outcome of one request, valid in the cycle in which done is high.
    typedef struct packed {
        logic done;
        logic success;
        logic full_error;
    } finish_t;

endpackage

// ===== rtl/core/iost_mem.sv =====
// ----------------------------------------------------------------------------
// Entry memory
// Simple dual-port synchronous RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module iost_mem #(
    parameter int DEPTH = iost_pkg::CAPACITY_DEFAULT,
    parameter int DW    = iost_pkg::VALUE_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/iost_ctrl.sv =====
// ----------------------------------------------------------------------------
// Set controller
// Runs the linear search over the stored entries, appends on add, and
// compacts the entries above a removed one by a read-ahead shift pass.
// ----------------------------------------------------------------------------
module iost_ctrl #(
    parameter int CAPACITY = iost_pkg::CAPACITY_DEFAULT,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [iost_pkg::REQ_W-1:0]        req_type,
    input  logic [iost_pkg::VALUE_W-1:0]      value,
    output logic                              busy,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [iost_pkg::VALUE_W-1:0]      wr_data,
    output logic                              rd_en,
    output logic [AW-1:0]                     rd_addr,
    input  logic [iost_pkg::VALUE_W-1:0]      rd_data,
    output iost_pkg::finish_t                 fin,
    output logic [CW-1:0]                     count
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    iost_pkg::req_type_t            req_reg, req_next;
    logic [iost_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic [AW-1:0]                  pend_idx_reg, pend_idx_next;
    logic                           match;
    logic                           scan_over;
    iost_pkg::req_type_t            req_in;

    assign req_in    = iost_pkg::req_type_t'(req_type);
    // A read issued last cycle returned the value being looked for.
    assign match     = pend_reg && (rd_data == value_reg);
    // Every valid entry has been read and compared without a hit.
    assign scan_over = !pend_reg && (idx_reg >= count_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        req_next      = req_reg;
        value_next    = value_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = value_reg;
        fin           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_in;
                    value_next = value;
                    idx_next   = '0;
                    if (req_in == iost_pkg::REQ_CLEAR)
                    begin
                        count_next = '0;
                        fin.done   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (match)
                begin
                    if (req_reg == iost_pkg::REQ_REMOVE)
                    begin
                        // Start compaction with the entry just above the hit.
                        state_next = ST_SHIFT;
                        idx_next   = CW'(pend_idx_reg) + CW'(1);
                    end
                    else
                    begin
                        state_next  = ST_IDLE;
                        fin.done    = 1'b1;
                        fin.success = (req_reg == iost_pkg::REQ_CONTAINS);
                    end
                end
                else if (scan_over)
                begin
                    state_next = ST_IDLE;
                    fin.done   = 1'b1;
                    if (req_reg == iost_pkg::REQ_ADD)
                    begin
                        if (count_reg < CAP_C)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[AW-1:0];
                            wr_data     = value_reg;
                            count_next  = count_reg + CW'(1);
                            fin.success = 1'b1;
                        end
                        else
                        begin
                            fin.full_error = 1'b1;
                        end
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    idx_next      = idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                end
            end

            ST_SHIFT:
            begin
                // Entry read last cycle moves down one slot.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg - AW'(1);
                    wr_data = rd_data;
                end
                if (idx_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    idx_next      = idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                end
                else if (!pend_reg)
                begin
                    state_next  = ST_IDLE;
                    count_next  = count_reg - CW'(1);
                    fin.done    = 1'b1;
                    fin.success = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    // The count as it stands once this cycle's request step has taken effect.
    assign count = count_next;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("member count exceeds capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == iost_pkg::REQ_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the set");

    a_full_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        fin.full_error |-> (fin.done && (req_reg == iost_pkg::REQ_ADD)
                            && (count_reg == CAP_C)))
        else $error("full error outside a refused add");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != ST_IDLE))
        else $error("memory write while idle");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (idx_reg < count_reg))
        else $error("read beyond the valid entries");

endmodule

// ===== rtl/core/insertion_ordered_set_table_top.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered set table
// Bounded set of distinct 32-bit values kept in insertion order, with add,
// remove, membership query and clear requests.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result is
// shown on success, full_error, member_count and is_empty for exactly one
// cycle while done is high, and the receiver cannot stall it. A clear takes
// effect at the edge that accepts it and its result is shown in the next
// cycle, with busy never raised. Every other request walks the stored
// entries through the read port of the entry memory, one entry per cycle:
// a search that misses reads every stored entry, and one that hits stops
// at slot pos. A remove that hits then compacts the entries above it
// through the same read port. The result register shows the result in
// the first cycle in which busy is low again. Busy falls at the edge that
// loads the result register, so the next item may be started in the cycle
// in which done is shown. Entries above the member count are never read,
// so the memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module insertion_ordered_set_table_top #(
    parameter int CAPACITY = iost_pkg::CAPACITY_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [iost_pkg::REQ_W-1:0]             req_type,
    input  logic signed [iost_pkg::VALUE_W-1:0]    value,
    output logic                                   busy,
    output logic                                   done,
    output logic                                   success,
    output logic                                   full_error,
    output logic [iost_pkg::COUNT_OUT_W-1:0]       member_count,
    output logic                                   is_empty
);

    // Slot address width and the width of a count that can reach CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [iost_pkg::VALUE_W-1:0]      wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic [iost_pkg::VALUE_W-1:0]      rd_data;
    iost_pkg::finish_t                 fin;
    logic [CW-1:0]                     count;

    logic                              done_reg;
    logic                              success_reg;
    logic                              full_error_reg;
    logic [iost_pkg::COUNT_OUT_W-1:0]  member_count_reg;
    logic                              is_empty_reg;

    // The controller sequences every request through the entry memory.
    iost_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .value    (value),
        .busy     (busy),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .fin      (fin),
        .count    (count)
    );

    // The stored values, packed from slot 0 in insertion order.
    iost_mem #(
        .DEPTH (CAPACITY),
        .DW    (iost_pkg::VALUE_W),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The result register raises done for one cycle per result. The controller
    // hands over the count that the finishing request leaves behind, so the
    // count loaded here is already the count after the request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.done;
        end
    end

    // The member count field is five bits wide; a capacity above 31 wraps it.
    always_ff @(posedge clk)
    begin
        if (fin.done)
        begin
            success_reg      <= fin.success;
            full_error_reg   <= fin.full_error;
            member_count_reg <= iost_pkg::COUNT_OUT_W'(count);
            is_empty_reg     <= (count == '0);
        end
    end

    assign done         = done_reg;
    assign success      = success_reg;
    assign full_error   = full_error_reg;
    assign member_count = member_count_reg;
    assign is_empty     = is_empty_reg;

endmodule

// ===== verif/iost_outcome_tracker_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered set table outcome tracker
// Mirrors the set contents and queues the outcome each accepted request
// should produce, then checks the results the block reports.
// ----------------------------------------------------------------------------
package iost_outcome_tracker_pkg;

    import iost_pkg::*;

    localparam int SET_DEPTH = CAPACITY_DEFAULT;

    typedef struct packed {
        logic                   success;
        logic                   full_error;
        logic [COUNT_OUT_W-1:0] member_count;
        logic                   is_empty;
    } set_outcome_t;

    class iost_outcome_tracker;

        logic [VALUE_W-1:0] held_values[SET_DEPTH];
        int unsigned        held_count;
        set_outcome_t       pending_outcomes[$];
        int unsigned        mismatch_count;
        int unsigned        result_index;

        function new();
            held_count     = 0;
            mismatch_count = 0;
            result_index   = 0;
        endfunction

        // Slot of v among the held values, or -1 when it is not a member.
        function int slot_of(logic [VALUE_W-1:0] v);
            for (int i = 0; i < held_count; i++) begin
                if (held_values[i] == v) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Applies one request to the mirror and returns the outcome it yields.
        function set_outcome_t apply_request(req_type_t req, logic [VALUE_W-1:0] v);
            set_outcome_t outcome;
            int           pos;
            outcome = '0;
            pos     = slot_of(v);
            case (req)
                REQ_ADD:
                begin
                    if (pos < 0) begin
                        if (held_count < SET_DEPTH) begin
                            held_values[held_count] = v;
                            held_count++;
                            outcome.success = 1'b1;
                        end
                        else begin
                            outcome.full_error = 1'b1;
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (pos >= 0) begin
                        for (int j = pos; j + 1 < held_count; j++) begin
                            held_values[j] = held_values[j + 1];
                        end
                        held_count--;
                        outcome.success = 1'b1;
                    end
                end
                REQ_CONTAINS:
                begin
                    outcome.success = (pos >= 0);
                end
                default:
                begin
                    held_count = 0;
                end
            endcase
            outcome.member_count = held_count[COUNT_OUT_W-1:0];
            outcome.is_empty     = (held_count == 0);
            return outcome;
        endfunction

        function void note_request(req_type_t req, logic [VALUE_W-1:0] v);
            pending_outcomes.push_back(apply_request(req, v));
        endfunction

        function int unsigned outstanding();
            return pending_outcomes.size();
        endfunction

        task report_mismatch(string what);
            $display("%0t: result %0d: %s", $realtime, result_index, what);
            mismatch_count++;
        endtask

        task check_outcome(set_outcome_t seen);
            set_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end
            else begin
                want = pending_outcomes.pop_front();
                if (seen.success !== want.success) begin
                    report_mismatch($sformatf("success expected %0b got %0b",
                                              want.success, seen.success));
                end
                if (seen.full_error !== want.full_error) begin
                    report_mismatch($sformatf("full_error expected %0b got %0b",
                                              want.full_error, seen.full_error));
                end
                if (seen.member_count !== want.member_count) begin
                    report_mismatch($sformatf("member_count expected %0d got %0d",
                                              want.member_count, seen.member_count));
                end
                if (seen.is_empty !== want.is_empty) begin
                    report_mismatch($sformatf("is_empty expected %0b got %0b",
                                              want.is_empty, seen.is_empty));
                end
            end
            result_index++;
        endtask

    endclass

endpackage

// ===== verif/insertion_ordered_set_table_top_test.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered set table testbench
// Drives add, remove, contains and clear requests into the set table, keeps
// a mirror of the set in a tracker object and checks every reported result
// field by field against the outcome the mirror predicts.
// ----------------------------------------------------------------------------
module insertion_ordered_set_table_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Every request finishes well within STALL_LIMIT, so running up to that
    // limit with no item moving on either side can only mean the block has
    // hung.
    localparam int STALL_LIMIT  = 4000;
    // Cycles to keep watching after the last result for stray results.
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int POOL_SIZE    = 24;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic [iost_pkg::REQ_W-1:0]          req_type;
    logic signed [iost_pkg::VALUE_W-1:0] value;
    logic                                busy;
    logic                                done;
    logic                                success;
    logic                                full_error;
    logic [iost_pkg::COUNT_OUT_W-1:0]    member_count;
    logic                                is_empty;

    iost_outcome_tracker_pkg::iost_outcome_tracker tracker = new();

    // While this is set the sender adds no random idle gaps between items.
    logic        quiet_stretch;
    int unsigned accepted_items;
    int unsigned stall_cycles;
    int unsigned episode_count;

    // Values drawn for one episode. The first four slots always hold the extremes
    // of the signed range, zero and minus one, so that they keep coming back as members.
    logic [iost_pkg::VALUE_W-1:0] value_pool[POOL_SIZE];

    insertion_ordered_set_table_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .value        (value),
        .busy         (busy),
        .done         (done),
        .success      (success),
        .full_error   (full_error),
        .member_count (member_count),
        .is_empty     (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Results are sampled in the active region of the rising edge, so they
    // are the values the block held just before that edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            tracker.check_outcome(iost_outcome_tracker_pkg::set_outcome_t'{
                success, full_error, member_count, is_empty});
        end
    end

    // The watchdog restarts its count whenever an item is taken or a result
    // is shown; it only runs out if the block stops making progress.
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("insertion_ordered_set_table_top verification failed");
        $finish;
    end

    // Offers one item and returns once the block has taken it. Start stays
    // high after acceptance; the next call either lowers it to idle or
    // presents the next item in the same step, never both.
    task automatic issue_request(iost_pkg::req_type_t req,
                                 logic [iost_pkg::VALUE_W-1:0] v);
        if (!quiet_stretch)
        begin
            while ($urandom_range(99) < 18)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start    <= 1'b1;
        req_type <= req;
        value    <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        tracker.note_request(req, v);
        accepted_items++;
    endtask

    // Holds the sender off until every outstanding result has come back, so
    // the block starts the next item from a fully idle state.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (tracker.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic refresh_pool();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            value_pool[i] = $urandom;
        end
    endtask

    function automatic logic [iost_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 85)
        begin
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // Fills the set past its capacity so that full adds, a duplicate add on
    // a full set and removes from a full set all occur, then mixes a few
    // requests while it is still nearly full.
    task automatic fill_episode();
        issue_request(iost_pkg::REQ_CLEAR, $urandom);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            issue_request(iost_pkg::REQ_ADD, value_pool[i]);
        end
        issue_request(iost_pkg::REQ_ADD,
            value_pool[$urandom_range(iost_outcome_tracker_pkg::SET_DEPTH - 1)]);
        issue_request(iost_pkg::REQ_CONTAINS, value_pool[$urandom_range(POOL_SIZE - 1)]);
        for (int i = 0; i < 6; i++)
        begin
            issue_request(iost_pkg::REQ_REMOVE, value_pool[$urandom_range(POOL_SIZE - 1)]);
            issue_request(iost_pkg::REQ_ADD, pick_value());
        end
    endtask

    // Mostly membership traffic on the pool, with the odd clear.
    task automatic mixed_episode();
        int unsigned roll;
        for (int i = 0; i < 24; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
            begin
                issue_request(iost_pkg::REQ_ADD, pick_value());
            end
            else if (roll < 65)
            begin
                issue_request(iost_pkg::REQ_REMOVE, pick_value());
            end
            else if (roll < 95)
            begin
                issue_request(iost_pkg::REQ_CONTAINS, pick_value());
            end
            else
            begin
                issue_request(iost_pkg::REQ_CLEAR, $urandom);
            end
        end
    endtask

    // Fully random request codes and values; these rarely hit a member.
    task automatic noise_episode();
        for (int i = 0; i < 12; i++)
        begin
            issue_request(iost_pkg::req_type_t'($urandom_range(3)), $urandom);
        end
    endtask

    initial
    begin
        int unsigned roll;
        int unsigned random_goal;
        start          = 1'b0;
        req_type       = iost_pkg::REQ_ADD;
        value          = '0;
        rst_n          = 1'b0;
        quiet_stretch  = 1'b0;
        accepted_items = 0;
        episode_count  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The set starts empty, so the first requests check
        // that clear, contains and remove on an empty set touch no entry.
        issue_request(iost_pkg::REQ_CLEAR, 32'h0000_0000);
        issue_request(iost_pkg::REQ_CONTAINS, 32'h0000_0000);
        issue_request(iost_pkg::REQ_REMOVE, 32'h0000_0000);
        // The extremes of the signed range, zero and minus one, then a duplicate add.
        issue_request(iost_pkg::REQ_ADD, 32'h8000_0000);
        issue_request(iost_pkg::REQ_ADD, 32'h7FFF_FFFF);
        issue_request(iost_pkg::REQ_ADD, 32'h0000_0000);
        issue_request(iost_pkg::REQ_ADD, 32'hFFFF_FFFF);
        issue_request(iost_pkg::REQ_ADD, 32'h7FFF_FFFF);
        issue_request(iost_pkg::REQ_CONTAINS, 32'h8000_0000);
        issue_request(iost_pkg::REQ_CONTAINS, 32'hFFFF_FFFF);
        issue_request(iost_pkg::REQ_CONTAINS, 32'h0000_0001);
        // A remove from the middle shifts the later entries down; the moved
        // entry must still be found afterwards.
        issue_request(iost_pkg::REQ_REMOVE, 32'h7FFF_FFFF);
        issue_request(iost_pkg::REQ_CONTAINS, 32'h0000_0000);
        issue_request(iost_pkg::REQ_CONTAINS, 32'h7FFF_FFFF);
        // Remove the first and the last entry, then an absent value.
        issue_request(iost_pkg::REQ_REMOVE, 32'h8000_0000);
        issue_request(iost_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
        issue_request(iost_pkg::REQ_REMOVE, 32'h1234_5678);
        issue_request(iost_pkg::REQ_ADD, 32'h5555_5555);
        issue_request(iost_pkg::REQ_ADD, 32'hAAAA_AAAA);
        // Clear ignores its value; nothing is a member afterwards.
        issue_request(iost_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
        issue_request(iost_pkg::REQ_CONTAINS, 32'h5555_5555);
        issue_request(iost_pkg::REQ_ADD, 32'hAAAA_AAAA);
        wait_for_drain();

        // Random part, built from episodes. The first one always fills the
        // set so that the full cases are seen early in every run.
        random_goal = accepted_items + RANDOM_ITEMS;
        while (accepted_items < random_goal)
        begin
            quiet_stretch = (accepted_items >= 800) && (accepted_items < 1100);
            refresh_pool();
            roll = $urandom_range(99);
            if (episode_count == 0 || roll < 30)
            begin
                fill_episode();
            end
            else if (roll < 85)
            begin
                mixed_episode();
            end
            else
            begin
                noise_episode();
            end
            episode_count++;
            if (episode_count % 10 == 0)
            begin
                wait_for_drain();
            end
        end
        start <= 1'b0;

        while (tracker.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0)
        begin
            $display("insertion_ordered_set_table_top verification clean");
        end
        else
        begin
            $display("insertion_ordered_set_table_top verification failed");
        end
        $finish;
    end

endmodule
